// ===== hw/rtl/log_record_deframer_crc32_core_defines.svh =====
// Assertion helpers for the log record deframer.
`ifndef LOG_RECORD_DEFRAMER_CRC32_CORE_DEFINES_SVH
`define LOG_RECORD_DEFRAMER_CRC32_CORE_DEFINES_SVH

// Clocked property, ignored while reset is asserted.
`define LRDC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked property that also holds during reset.
`define LRDC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hw/rtl/lrdc_pkg.sv =====
package lrdc_pkg;

  localparam logic [31:0] REC_MAGIC = 32'h524C_4157;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  // index of the last header byte (header is 12 bytes)
  localparam logic [3:0]  HDR_LAST  = 4'd11;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_SKIP    = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_NONE  = 3'd0,
    ST_OK    = 3'd1,
    ST_MAGIC = 3'd2,
    ST_CRC   = 3'd3,
    ST_TORN  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    HW_MAGIC  = 2'd0,
    HW_LENGTH = 2'd1,
    HW_CRC    = 2'd2
  } hdr_word_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_log;
  } in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    status_e    status;
    logic       log_end;
  } out_t;

endpackage

// ===== hw/rtl/log_record_deframer_crc32_core.sv =====
// Pipeline: input register, then result register; while the result is stalled, the next
// byte is held in the input register.
// Throughput: one byte per cycle while the result is not stalled; the byte-wide CRC-32
// update and the 32-bit payload counter set the cycle time.
// Reset: asynchronous, active low; empties both registers and returns the
// deframer to header scan with a fresh CRC.
module log_record_deframer_crc32_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lrdc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lrdc_pkg::out_t out_data_o
);
  import lrdc_pkg::*;

  logic        in_valid_q;
  in_t         in_q;
  logic        out_valid_q;
  out_t        out_q, out_d;

  phase_e      phase_q, phase_d;
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] magic_q, magic_d;
  logic [31:0] len_q, len_d;
  logic [31:0] crcx_q, crcx_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] left_q, left_d;

  logic        advance, fire, eol;
  logic [7:0]  b;
  logic [31:0] byte_word, magic_new, len_new, crcx_new, crc_new, left_new;
  logic        hdr_last, magic_ok, len_zero, hdr_crc_ok, pay_done, pay_crc_ok;
  hdr_word_e   word_sel;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  assign b   = in_q.data_byte;
  assign eol = in_q.end_of_log;

  // header byte lands in its little-endian lane of the word it belongs to
  assign word_sel  = hdr_word_e'(hdr_cnt_q[3:2]);
  assign byte_word = {24'd0, b} << {hdr_cnt_q[1:0], 3'b000};
  assign magic_new = magic_q | ((word_sel == HW_MAGIC)  ? byte_word : 32'd0);
  assign len_new   = len_q   | ((word_sel == HW_LENGTH) ? byte_word : 32'd0);
  assign crcx_new  = crcx_q  | ((word_sel == HW_CRC)    ? byte_word : 32'd0);

  assign hdr_last   = (hdr_cnt_q == HDR_LAST);
  assign magic_ok   = (magic_new == REC_MAGIC);
  assign len_zero   = (len_new == 32'd0);
  // CRC of an empty payload is zero
  assign hdr_crc_ok = (crcx_new == 32'd0);

  lrdc_crc_byte u_crc (
    .crc_i  (crc_q),
    .byte_i (b),
    .crc_o  (crc_new)
  );

  assign left_new   = (left_q != 32'd0) ? left_q - 32'd1 : left_q;
  assign pay_done   = (left_new == 32'd0);
  assign pay_crc_ok = ((crc_new ^ CRC_INIT) == crcx_q);

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_HEADER: begin
        if (hdr_last) begin
          if (!magic_ok) begin
            phase_d = PH_SKIP;
          end else if (len_zero) begin
            phase_d = hdr_crc_ok ? PH_HEADER : PH_SKIP;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (pay_done) begin
          phase_d = pay_crc_ok ? PH_HEADER : PH_SKIP;
        end
      end
      PH_SKIP: phase_d = PH_SKIP;
      default: phase_d = PH_HEADER;
    endcase
    if (eol) begin
      phase_d = PH_HEADER;
    end
  end

  // result and datapath state
  always_comb begin
    logic restart;
    restart            = eol;
    out_d.payload_byte  = 8'd0;
    out_d.payload_valid = 1'b0;
    out_d.status        = ST_NONE;
    out_d.log_end       = eol;
    hdr_cnt_d = hdr_cnt_q;
    magic_d   = magic_q;
    len_d     = len_q;
    crcx_d    = crcx_q;
    crc_d     = crc_q;
    left_d    = left_q;
    case (phase_q)
      PH_HEADER: begin
        magic_d   = magic_new;
        len_d     = len_new;
        crcx_d    = crcx_new;
        hdr_cnt_d = hdr_last ? 4'd0 : hdr_cnt_q + 4'd1;
        if (hdr_last) begin
          if (!magic_ok) begin
            out_d.status = ST_MAGIC;
          end else if (len_zero) begin
            if (hdr_crc_ok) begin
              out_d.status = ST_OK;
              restart      = 1'b1;
            end else begin
              out_d.status = eol ? ST_TORN : ST_CRC;
            end
          end else begin
            left_d       = len_new;
            crc_d        = CRC_INIT;
            out_d.status = eol ? ST_TORN : ST_NONE;
          end
        end else if (eol) begin
          out_d.status = ST_TORN;
        end
      end
      PH_PAYLOAD: begin
        out_d.payload_byte  = b;
        out_d.payload_valid = 1'b1;
        crc_d  = crc_new;
        left_d = left_new;
        if (pay_done) begin
          if (pay_crc_ok) begin
            out_d.status = ST_OK;
            restart      = 1'b1;
          end else begin
            out_d.status = eol ? ST_TORN : ST_CRC;
          end
        end else if (eol) begin
          out_d.status = ST_TORN;
        end
      end
      default: ;
    endcase
    if (restart) begin
      hdr_cnt_d = 4'd0;
      magic_d   = 32'd0;
      len_d     = 32'd0;
      crcx_d    = 32'd0;
      crc_d     = CRC_INIT;
      left_d    = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= 4'd0;
      magic_q     <= 32'd0;
      len_q       <= 32'd0;
      crcx_q      <= 32'd0;
      crc_q       <= CRC_INIT;
      left_q      <= 32'd0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        phase_q   <= phase_d;
        hdr_cnt_q <= hdr_cnt_d;
        magic_q   <= magic_d;
        len_q     <= len_d;
        crcx_q    <= crcx_d;
        crc_q     <= crc_d;
        left_q    <= left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/lrdc_crc_byte.sv =====
module lrdc_crc_byte (
  input  logic [31:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);
  import lrdc_pkg::*;

  // reflected CRC-32, one byte per call: eight shift/xor steps
  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'd0, byte_i};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    crc_o = c;
  end

endmodule

// ===== hw/rtl/lrdc_checker.sv =====
`include "log_record_deframer_crc32_core_defines.svh"

module lrdc_assertions (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input lrdc_pkg::out_t out_data_o
);
  import lrdc_pkg::*;

  `LRDC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  // input only backs up when the result register is full and held off
  `LRDC_ASSERT(a_in_stall_full, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i, "input stalled with room")

  // torn tail is only reported on the byte that ends the log
  `LRDC_ASSERT(a_torn_at_end, clk_i, rst_ni, out_valid_o && (out_data_o.status == ST_TORN) |-> out_data_o.log_end, "torn tail without log end")

  // a bad-magic verdict never comes with a payload byte; idle byte lane is zero
  `LRDC_ASSERT(a_payload_lane, clk_i, rst_ni, out_valid_o |-> (out_data_o.payload_valid ? (out_data_o.status != ST_MAGIC) : (out_data_o.payload_byte == 8'd0)), "payload lane inconsistent")

  `LRDC_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind log_record_deframer_crc32_core lrdc_assertions u_lrdc_assertions (.*);
